@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker in spq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("port check failed");

// Plain condition that must hold on every rising clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("port invariant failed");

`endif

@@ rtl/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

   localparam int ID_W        = 4;
   localparam int ID_SPACE    = 16;
   localparam int PRIO_W      = 32;
   localparam int LIMIT_W     = 5;
   localparam int COUNT_OUT_W = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
   localparam logic signed [PRIO_W-1:0] PRIO_MAX = 32'sd255999744;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_REJECTED = 2'd1;
   localparam logic [1:0] ST_REMOVED  = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   // one queue slot
   typedef struct packed {
      logic                     valid;
      logic [ID_W-1:0]          id;
      logic signed [PRIO_W-1:0] prio;
   } slot_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic                     insert;
      logic                     remove;
      logic [ID_W-1:0]          id;
      logic signed [PRIO_W-1:0] prio;
   } cmd_type;

endpackage
`default_nettype wire

@@ rtl/sorted_priority_queue_top.sv @@
`default_nettype none
// Channel   Ports                                        Direction  Handshake
// request   start, busy, req_kind/entry_id/priority_req  in         start && !busy
// response  rsp_valid, rsp_status/out_id/out_priority/   out        rsp_valid, one cycle
//           rsp_entry_count
// config    csr_valid, csr_ready, csr_id_limit           in         csr_valid && csr_ready
//
// Each request's response is registered and shows on the next cycle.
// busy stays low, so a new request can be taken on every clock.
// The cells compare the new priority in parallel; the compare in each cell
// and the shift to its neighbor set the cycle, independent of QUEUE_DEPTH.
// Synchronous reset empties the queue, clears the id table, sets id_limit to 16.
// The receiver cannot stall: each response is valid for exactly one cycle.
module sorted_priority_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_kind,
   input  wire logic [spq_pkg::ID_W-1:0]         req_entry_id,
   input  wire logic signed [spq_pkg::PRIO_W-1:0] req_priority_req,
   // response channel
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [spq_pkg::ID_W-1:0]              rsp_out_id,
   output logic signed [spq_pkg::PRIO_W-1:0]     rsp_out_priority,
   output logic [spq_pkg::COUNT_OUT_W-1:0]       rsp_entry_count,
   // configuration channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [spq_pkg::LIMIT_W-1:0]      csr_id_limit
);
   import spq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // control state
   logic [LIMIT_W-1:0]  limit_ff;
   logic [ID_SPACE-1:0] present_ff;
   logic [ID_SPACE-1:0] present_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;

   // response registers
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic [1:0]               rsp_status_in;
   logic [ID_W-1:0]          rsp_out_id_ff;
   logic [ID_W-1:0]          rsp_out_id_in;
   logic signed [PRIO_W-1:0] rsp_out_priority_ff;
   logic signed [PRIO_W-1:0] rsp_out_priority_in;
   logic [COUNT_OUT_W-1:0]   rsp_entry_count_ff;
   logic [CW+COUNT_OUT_W-1:0] count_wide;

   logic     accept;
   logic     reject;
   logic     full;
   cmd_type  cmd;
   slot_type slots [QUEUE_DEPTH];
   logic     keeps [QUEUE_DEPTH];
   slot_type empty_slot;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign full      = (count_ff == CW'(QUEUE_DEPTH));

   // insert is refused on a bad id, too large a priority, a queued id or a full queue
   assign reject = ({1'b0, req_entry_id} >= limit_ff) ||
                   (req_priority_req > PRIO_MAX) ||
                   present_ff[req_entry_id] || full;

   always_comb begin
      cmd.insert = accept && (req_kind == KIND_INSERT) && !reject;
      cmd.remove = accept && (req_kind == KIND_REMOVE) && slots[0].valid;
      cmd.id     = req_entry_id;
      cmd.prio   = req_priority_req;
   end

   always_comb begin
      empty_slot       = slots[0];
      empty_slot.valid = 1'b0;
   end

   // the chain: cell 0 is the head; inserts ripple toward the tail,
   // removes pull every entry one cell toward the head
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      slot_type left_slot;
      logic     left_keep;
      slot_type right_slot;
      if (i == 0) begin : g_head
         assign left_slot = empty_slot;
         assign left_keep = 1'b1;
      end else begin : g_body
         assign left_slot = slots[i-1];
         assign left_keep = keeps[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_slot = empty_slot;
      end else begin : g_inner
         assign right_slot = slots[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_slot  (left_slot),
         .left_keep  (left_keep),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .keep       (keeps[i])
      );
   end

   // next id table, count and response
   always_comb begin
      present_in          = present_ff;
      count_in            = count_ff;
      rsp_status_in       = ST_EMPTY;
      rsp_out_id_in       = '0;
      rsp_out_priority_in = '0;
      if (req_kind == KIND_INSERT) begin
         if (reject) begin
            rsp_status_in = ST_REJECTED;
         end else begin
            rsp_status_in            = ST_INSERTED;
            present_in[req_entry_id] = 1'b1;
            count_in                 = count_ff + CW'(1);
         end
      end else if (slots[0].valid) begin
         rsp_status_in            = ST_REMOVED;
         rsp_out_id_in            = slots[0].id;
         rsp_out_priority_in      = slots[0].prio;
         present_in[slots[0].id]  = 1'b0;
         count_in                 = count_ff - CW'(1);
      end
   end

   // entry count reported modulo 32
   assign count_wide = {{COUNT_OUT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff           <= LIMIT_RESET;
         present_ff         <= '0;
         count_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
         rsp_entry_count_ff <= '0;
      end else begin
         rsp_valid_ff <= accept;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_id_limit;
         end
         if (accept) begin
            present_ff         <= present_in;
            count_ff           <= count_in;
            rsp_entry_count_ff <= count_wide[COUNT_OUT_W-1:0];
         end
      end
   end

   // payload of the response, loaded with each request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff       <= rsp_status_in;
         rsp_out_id_ff       <= rsp_out_id_in;
         rsp_out_priority_ff <= rsp_out_priority_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_id       = rsp_out_id_ff;
   assign rsp_out_priority = rsp_out_priority_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;

endmodule
`default_nettype wire

@@ rtl/spq_cell.sv @@
`default_nettype none
module spq_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire spq_pkg::cmd_type  cmd,
   input  wire spq_pkg::slot_type left_slot,
   input  wire logic             left_keep,
   input  wire spq_pkg::slot_type right_slot,
   output spq_pkg::slot_type      slot,
   output logic                  keep
);
   import spq_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   // stays put on insert: occupied and not below the new priority
   assign keep = slot_ff.valid && (slot_ff.prio >= cmd.prio);
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (cmd.remove) begin
         slot_in = right_slot;
      end else if (cmd.insert && !keep) begin
         if (left_keep) begin
            slot_in.valid = 1'b1;
            slot_in.id    = cmd.id;
            slot_in.prio  = cmd.prio;
         end else begin
            slot_in = left_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/spq_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module spq_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_valid,
   input wire logic [1:0]                        rsp_status,
   input wire logic [spq_pkg::ID_W-1:0]          rsp_out_id,
   input wire logic signed [spq_pkg::PRIO_W-1:0] rsp_out_priority,
   input wire logic [spq_pkg::COUNT_OUT_W-1:0]   rsp_entry_count
);
   import spq_pkg::*;

   // every accepted request answers on the next cycle, and nothing else does
   `CHK_ASSERT(a_rsp_follows_req, clock, reset, (start && !busy) |=> rsp_valid)
   `CHK_ASSERT(a_rsp_has_req, clock, reset, rsp_valid |-> $past(start && !busy))
   // only a remove carries an entry out
   `CHK_ASSERT(a_no_stray_payload, clock, reset,
      (rsp_valid && rsp_status != ST_REMOVED) |-> (rsp_out_id == '0 && rsp_out_priority == '0))
   // the count shown only moves with a response
   `CHK_ASSERT(a_count_holds, clock, reset, !rsp_valid |-> $stable(rsp_entry_count))
   // an empty report leaves the count at zero
   `CHK_ALWAYS(a_empty_zero, clock, reset,
      !(rsp_valid && rsp_status == ST_EMPTY) || rsp_entry_count == '0)

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_out_id       (rsp_out_id),
   .rsp_out_priority (rsp_out_priority),
   .rsp_entry_count  (rsp_entry_count)
);
`default_nettype wire
